// ===== rtl/core/sisi_pkg.sv =====
package sisi_pkg;

   localparam int DEF_CAPACITY = 64;

   localparam logic [2:0] OP_QUERY      = 3'd0;
   localparam logic [2:0] OP_ADD        = 3'd1;
   localparam logic [2:0] OP_REMOVE_FILE = 3'd2;
   localparam logic [2:0] OP_REMOVE_KEY = 3'd3;
   localparam logic [2:0] OP_SIZE       = 3'd4;
   localparam logic [2:0] OP_CLEAR      = 3'd5;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [2:0]         op;
      logic [15:0]        symbol_id;
      logic [7:0]         dtype;
      logic [7:0]         data_field;
      logic signed [63:0] low_ts;
      logic signed [63:0] high_ts;
      logic [15:0]        file_id;
      logic [7:0]         codec;
      logic [31:0]        num_rows;
      logic [31:0]        comp_bytes;
      logic [47:0]        byte_offset;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               last;
      logic               status;
      logic [6:0]         entry_count;
      logic [7:0]         out_field;
      logic signed [63:0] seg_min_ts;
      logic signed [63:0] seg_max_ts;
      logic [15:0]        seg_file_id;
      logic [7:0]         seg_codec;
      logic [31:0]        seg_rows;
      logic [31:0]        seg_bytes;
      logic [47:0]        seg_offset;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        key;
      logic signed [63:0] start_ts;
      logic signed [63:0] end_ts;
      logic [15:0]        file_id;
      logic [7:0]         codec;
      logic [31:0]        rows;
      logic [31:0]        bytes;
      logic [47:0]        offset;
   } entry_type;

endpackage

// ===== rtl/core/sisi_table.sv =====
module sisi_table #(
   parameter int CAPACITY = sisi_pkg::DEF_CAPACITY,
   parameter int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output sisi_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  sisi_pkg::entry_type wr_data
);
   import sisi_pkg::*;

   entry_type mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/sisi_ctrl.sv =====
module sisi_ctrl #(
   parameter int CAPACITY = sisi_pkg::DEF_CAPACITY,
   parameter int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   parameter int CW = $clog2(CAPACITY + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sisi_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sisi_pkg::rsp_type   rsp_data,
   output logic                rd_en,
   output logic [AW-1:0]       rd_addr,
   input  sisi_pkg::entry_type rd_data,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output sisi_pkg::entry_type wr_data
);
   import sisi_pkg::*;

   // scan: while index r is read, rd_data holds the entry for index r-1
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_SHIFT = 3'd2;
   localparam logic [2:0] ST_PUT   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]    state_ff, state_in;
   req_type       req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ff, rd_in;
   logic [CW-1:0] wp_ff, wp_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] pidx_ff, pidx_in;
   logic          hold_ff, hold_in;
   rsp_type       hold_data_ff, hold_data_in;
   logic          out_v_ff, out_v_in;
   rsp_type       out_ff, out_in;
   logic          full_ff, full_in;

   logic [31:0] fkey;
   logic        match;
   logic        drop;
   logic        ins_here;
   logic        out_free;
   rsp_type     plain;
   rsp_type     hitr;

   assign fkey = {req_ff.symbol_id, req_ff.dtype, req_ff.data_field};
   assign match = (rd_data.key == fkey) && (rd_data.start_ts <= req_ff.high_ts)
      && (req_ff.low_ts <= rd_data.end_ts);
   assign drop = (rd_data.key[31:8] == fkey[31:8])
      && ((req_ff.op == OP_REMOVE_KEY) || (rd_data.file_id == req_ff.file_id));
   assign ins_here = req_ff.low_ts <= rd_data.start_ts;
   assign out_free = !out_v_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      plain = '0;
      plain.last = 1'b1;
      plain.status = full_ff;
      plain.entry_count = 7'(count_ff);
      hitr = '0;
      hitr.hit = 1'b1;
      hitr.entry_count = 7'(count_ff);
      hitr.out_field = rd_data.key[7:0];
      hitr.seg_min_ts = rd_data.start_ts;
      hitr.seg_max_ts = rd_data.end_ts;
      hitr.seg_file_id = rd_data.file_id;
      hitr.seg_codec = rd_data.codec;
      hitr.seg_rows = rd_data.rows;
      hitr.seg_bytes = rd_data.bytes;
      hitr.seg_offset = rd_data.offset;
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      count_in = count_ff;
      rd_in = rd_ff;
      wp_in = wp_ff;
      pend_in = 1'b0;
      pidx_in = pidx_ff;
      hold_in = hold_ff;
      hold_data_in = hold_data_ff;
      out_v_in = out_v_ff && rsp_stall;
      out_in = out_ff;
      full_in = full_ff;
      rd_en = 1'b0;
      rd_addr = rd_ff[AW-1:0];
      wr_en = 1'b0;
      wr_addr = wp_ff[AW-1:0];
      wr_data = rd_data;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               rd_in = '0;
               wp_in = '0;
               hold_in = 1'b0;
               full_in = STATUS_OK;
               case (req_data.op)
                  OP_QUERY, OP_REMOVE_FILE, OP_REMOVE_KEY: state_in = ST_SCAN;
                  OP_ADD: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        full_in = STATUS_FULL;
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (req_ff.op == OP_QUERY) begin
               // one emitted hit held back so the final one can carry last
               if (out_free) begin
                  if (pend_ff && match) begin
                     if (hold_ff) begin
                        out_v_in = 1'b1;
                        out_in = hold_data_ff;
                     end
                     hold_in = 1'b1;
                     hold_data_in = hitr;
                  end
                  if (rd_ff < count_ff) begin
                     rd_en = 1'b1;
                     pend_in = 1'b1;
                     pidx_in = rd_ff;
                     rd_in = rd_ff + 1'b1;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  // stalled: re-read the pending entry
                  if (pend_ff) begin
                     rd_en = 1'b1;
                     rd_addr = pidx_ff[AW-1:0];
                     pend_in = 1'b1;
                  end
               end
            end else if (req_ff.op == OP_ADD) begin
               if (pend_ff && ins_here) begin
                  wp_in = pidx_ff;
                  rd_in = count_ff;
                  state_in = ST_SHIFT;
               end else if (rd_ff < count_ff) begin
                  rd_en = 1'b1;
                  pend_in = 1'b1;
                  pidx_in = rd_ff;
                  rd_in = rd_ff + 1'b1;
               end else begin
                  wp_in = count_ff;
                  state_in = ST_PUT;
               end
            end else begin
               if (pend_ff && !drop) begin
                  wr_en = 1'b1;
                  wp_in = wp_ff + 1'b1;
               end
               if (rd_ff < count_ff) begin
                  rd_en = 1'b1;
                  pend_in = 1'b1;
                  rd_in = rd_ff + 1'b1;
               end else begin
                  count_in = (pend_ff && !drop) ? wp_ff + 1'b1 : wp_ff;
                  state_in = ST_DONE;
               end
            end
         end
         ST_SHIFT: begin
            // move entries [wp, count) up by one, top first; rd_ff is the destination
            if (pend_ff) begin
               wr_en = 1'b1;
               wr_addr = pidx_ff[AW-1:0];
            end
            if (rd_ff > wp_ff) begin
               rd_en = 1'b1;
               rd_addr = AW'(rd_ff - 1'b1);
               pend_in = 1'b1;
               pidx_in = rd_ff;
               rd_in = rd_ff - 1'b1;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            wr_en = 1'b1;
            wr_addr = wp_ff[AW-1:0];
            wr_data.key = fkey;
            wr_data.start_ts = req_ff.low_ts;
            wr_data.end_ts = req_ff.high_ts;
            wr_data.file_id = req_ff.file_id;
            wr_data.codec = req_ff.codec;
            wr_data.rows = req_ff.num_rows;
            wr_data.bytes = req_ff.comp_bytes;
            wr_data.offset = req_ff.byte_offset;
            count_in = count_ff + 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_v_in = 1'b1;
               if (hold_ff) begin
                  out_in = hold_data_ff;
                  out_in.last = 1'b1;
               end else begin
                  out_in = plain;
               end
               out_in.entry_count = 7'(count_ff);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff <= 1'b0;
         hold_ff <= 1'b0;
         out_v_ff <= 1'b0;
         full_ff <= STATUS_OK;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff <= pend_in;
         hold_ff <= hold_in;
         out_v_ff <= out_v_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rd_ff <= rd_in;
      wp_ff <= wp_in;
      pidx_ff <= pidx_in;
      hold_data_ff <= hold_data_in;
      out_ff <= out_in;
   end

endmodule

// ===== rtl/core/sorted_interval_segment_index.sv =====
// Sorted interval segment index. Keeps up to CAPACITY segment descriptors in one
// single-port-read, single-port-write table, ordered by start time. One transaction
// is taken at a time (req_stall is high while one is in progress). A query walks
// every stored entry, one memory read a cycle while the response output is free; an
// add finds its slot by the same walk, stops there and shifts the entries above it
// one slot a cycle; removes compact the table in one pass; size and clear respond
// without walking the table. Each transaction gives one or more responses, the final
// one with last set.
module sorted_interval_segment_index #(
   parameter int CAPACITY = sisi_pkg::DEF_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sisi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sisi_pkg::rsp_type rsp_data
);
   import sisi_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;

   sisi_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   sisi_table #(.CAPACITY(CAPACITY)) u_table (
      .clock(clock),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

endmodule

// ===== rtl/core/sisi_checker.sv =====
module sisi_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input sisi_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sisi_pkg::rsp_type rsp_data
);
   import sisi_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_plain_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.last && rsp_data.seg_file_id == '0)
      else $error("non-hit response not plain");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.status == STATUS_OK)
      else $error("hit with full status");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= 7'd64)
      else $error("count out of range");

endmodule

bind sorted_interval_segment_index sisi_checker u_sisi_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

// ===== verif/sisi_checker.sv =====
`timescale 1ns / 100ps

module sisi_scoreboard #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  sisi_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  sisi_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   import sisi_pkg::*;

   entry_type table_q[$];
   rsp_type   awaited_q[$];

   task automatic queue_rsp(rsp_type r);
      awaited_q.insert(awaited_q.size(), r);
   endtask

   function automatic rsp_type plain_rsp(logic status);
      rsp_type r;
      r = '0;
      r.last = 1'b1;
      r.status = status;
      r.entry_count = 7'(table_q.size());
      return r;
   endfunction

   task automatic apply_request(req_type q);
      logic [31:0] fkey;
      logic [31:0] pkey;
      entry_type   e;
      rsp_type     r;
      int          pos;
      int          hits;
      fkey = {q.symbol_id, q.dtype, q.data_field};
      pkey = {q.symbol_id, q.dtype, 8'h00};
      hits = 0;
      case (q.op)
         OP_QUERY: begin
            foreach (table_q[i]) begin
               if (table_q[i].key == fkey && table_q[i].start_ts <= q.high_ts &&
                   q.low_ts <= table_q[i].end_ts) begin
                  r = '0;
                  r.hit = 1'b1;
                  r.entry_count = 7'(table_q.size());
                  r.out_field = table_q[i].key[7:0];
                  r.seg_min_ts = table_q[i].start_ts;
                  r.seg_max_ts = table_q[i].end_ts;
                  r.seg_file_id = table_q[i].file_id;
                  r.seg_codec = table_q[i].codec;
                  r.seg_rows = table_q[i].rows;
                  r.seg_bytes = table_q[i].bytes;
                  r.seg_offset = table_q[i].offset;
                  queue_rsp(r);
                  hits++;
               end
            end
            if (hits == 0) queue_rsp(plain_rsp(STATUS_OK));
            else awaited_q[awaited_q.size()-1].last = 1'b1;
         end
         OP_ADD: begin
            if (table_q.size() >= CAPACITY) begin
               queue_rsp(plain_rsp(STATUS_FULL));
            end else begin
               pos = table_q.size();
               foreach (table_q[i]) begin
                  if (q.low_ts <= table_q[i].start_ts) begin
                     pos = i;
                     break;
                  end
               end
               e.key = fkey;
               e.start_ts = q.low_ts;
               e.end_ts = q.high_ts;
               e.file_id = q.file_id;
               e.codec = q.codec;
               e.rows = q.num_rows;
               e.bytes = q.comp_bytes;
               e.offset = q.byte_offset;
               table_q.insert(pos, e);
               queue_rsp(plain_rsp(STATUS_OK));
            end
         end
         OP_REMOVE_FILE, OP_REMOVE_KEY: begin
            for (int i = table_q.size() - 1; i >= 0; i--) begin
               if (table_q[i].key[31:8] == pkey[31:8] &&
                   (q.op == OP_REMOVE_KEY || table_q[i].file_id == q.file_id))
                  table_q.delete(i);
            end
            queue_rsp(plain_rsp(STATUS_OK));
         end
         OP_CLEAR: begin
            table_q.delete();
            queue_rsp(plain_rsp(STATUS_OK));
         end
         default: queue_rsp(plain_rsp(STATUS_OK));
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         table_q.delete();
         awaited_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected transaction: %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited_q.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p actual %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) apply_request(req_data);
         pending <= awaited_q.size();
      end
   end
endmodule

// ===== verif/tb_sorted_interval_segment_index.sv =====
`timescale 1ns / 100ps

module tb_sorted_interval_segment_index;
   import sisi_pkg::*;

   localparam int CAP = 64;
   localparam int LIMIT = 2000000;
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      cycles = 0;
   bit      stall_on = 1'b1;

   logic signed [63:0] ts_pool [6];
   logic [15:0] sym_pool [3] = '{16'h0000, 16'hFFFF, 16'h1234};

   always #4 clock = ~clock;

   sorted_interval_segment_index #(.CAPACITY(CAP)) dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   sisi_scoreboard #(.CAPACITY(CAP)) checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .fail_count, .pending
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   always @(negedge clock) begin
      if (!stall_on) rsp_stall <= 1'b0;
      else if (rsp_stall) rsp_stall <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
      else rsp_stall <= ($urandom_range(0, 4) == 0);
   end

   task automatic send(req_type q);
      int g;
      g = gap_len();
      repeat (g + 1) @(negedge clock);
      req_valid <= 1'b1;
      req_data <= q;
      while (req_stall) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic req_type rand_req(logic [2:0] op, bit narrow);
      req_type q;
      logic [319:0] bits;
      logic signed [63:0] a, b;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom};
      q = bits[$bits(req_type)-1:0];
      q.op = op;
      if (narrow) begin
         q.symbol_id = sym_pool[$urandom_range(0, 2)];
         q.dtype = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         q.data_field = 8'($urandom_range(0, 2));
         q.file_id = 16'($urandom_range(0, 3));
         a = ts_pool[$urandom_range(0, 5)] + $signed(64'($urandom_range(0, 40)) - 64'sd20);
         b = a + 64'($urandom_range(0, 60)) - 64'sd5;
         q.low_ts = a;
         q.high_ts = b;
      end
      return q;
   endfunction

   initial begin
      req_type q;
      int r;
      ts_pool = '{64'sh8000000000000000, 64'sh7FFFFFFFFFFFFF00, -64'sd100, 64'sd0,
                  64'sd100, 64'sd5000};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      q = '0; q.op = OP_QUERY; send(q);
      q = '0; q.op = OP_SIZE; send(q);
      q = '1; q.op = OP_ADD; q.low_ts = 64'sh8000000000000000;
      q.high_ts = 64'sh7FFFFFFFFFFFFFFF; send(q);
      q = '0; q.op = OP_ADD; q.low_ts = 64'sh7FFFFFFFFFFFFFFF; q.high_ts = q.low_ts; send(q);
      q = '0; q.op = OP_ADD; send(q);
      q = '0; q.op = OP_ADD; send(q);
      q = '1; q.op = OP_QUERY; q.low_ts = 64'sh8000000000000000;
      q.high_ts = 64'sh7FFFFFFFFFFFFFFF; send(q);
      q = '0; q.op = OP_QUERY; q.low_ts = 64'sh8000000000000000;
      q.high_ts = 64'sh7FFFFFFFFFFFFFFF; send(q);
      q = '0; q.op = OP_QUERY; q.low_ts = 64'sd10; q.high_ts = -64'sd10; send(q);
      q = '0; q.op = OP_SPARE_LO; send(q);
      q = '1; q.op = OP_SPARE_HI; send(q);
      q = '0; q.op = OP_REMOVE_FILE; q.file_id = 16'h0001; send(q);
      q = '0; q.op = OP_REMOVE_FILE; send(q);
      q = '1; q.op = OP_REMOVE_KEY; send(q);
      q = '0; q.op = OP_SIZE; send(q);
      for (int i = 0; i < CAP + 2; i++) begin
         q = rand_req(OP_ADD, 1'b1);
         stall_on = (i < 20) || (i > 50);
         send(q);
      end
      stall_on = 1'b1;
      q = rand_req(OP_QUERY, 1'b1); send(q);
      q = '0; q.op = OP_CLEAR; send(q);

      while (pending != 0) @(posedge clock);

      for (int i = 0; i < 30; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) q = rand_req(OP_ADD, 1'b1);
         else if (r < 75) q = rand_req(OP_QUERY, 1'b1);
         else if (r < 83) q = rand_req(OP_REMOVE_FILE, 1'b1);
         else if (r < 88) q = rand_req(OP_REMOVE_KEY, 1'b1);
         else if (r < 92) q = rand_req(OP_SIZE, 1'b0);
         else if (r < 95) q = rand_req(OP_CLEAR, 1'b0);
         else q = rand_req(3'($urandom_range(0, 7)), 1'b0);
         send(q);
         if (i == 15) while (pending != 0) @(posedge clock);
      end

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
